>>> design/bmprle_pkg.sv
`timescale 1ns / 1ps

package bmprle_pkg;

  // lane configuration: only four pixel fields exist on the result
  localparam int unsigned LANES        = 4;
  localparam int unsigned PIXEL_FIELDS = 4;
  localparam int unsigned PER_RESULT   = (LANES > PIXEL_FIELDS) ? PIXEL_FIELDS : LANES;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CNT_W = 3;

  // parse phases plus the fill drain state
  typedef enum logic [2:0] {
    ST_COUNT   = 3'd0,
    ST_VALUE   = 3'd1,
    ST_ESCAPE  = 3'd2,
    ST_DELTA_X = 3'd3,
    ST_DELTA_Y = 3'd4,
    ST_ABS     = 3'd5,
    ST_PAD     = 3'd6,
    ST_FILL    = 3'd7
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_RUN,
    OP_FILL_START,
    OP_FILL_NEXT,
    OP_EOL,
    OP_EOB,
    OP_ABS_START,
    OP_ABS_BYTE,
    OP_PAD
  } op_e;

  // datapath status toward the controller
  typedef struct packed {
    logic can_emit;
    logic byte_zero;
    logic byte_one;
    logic byte_two;
    logic fill_last_start;
    logic fill_last_next;
    logic bytes_done;
    logic pad_pending;
  } dp_status_t;

endpackage

>>> design/bmprle_ctrl.sv
`timescale 1ns / 1ps

module bmprle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bmprle_pkg::dp_status_t status_i,
  output bmprle_pkg::op_e        op_o
);
  import bmprle_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && !in_stall_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COUNT: begin
        if (accept) begin
          state_d = status_i.byte_zero ? ST_ESCAPE : ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (accept) begin
          state_d = status_i.fill_last_start ? ST_COUNT : ST_FILL;
        end
      end
      ST_FILL: begin
        if (status_i.can_emit && status_i.fill_last_next) begin
          state_d = ST_COUNT;
        end
      end
      ST_ESCAPE: begin
        if (accept) begin
          priority if (status_i.byte_zero || status_i.byte_one) begin
            state_d = ST_COUNT;
          end else if (status_i.byte_two) begin
            state_d = ST_DELTA_X;
          end else begin
            state_d = ST_ABS;
          end
        end
      end
      ST_DELTA_X: begin
        if (accept) begin
          state_d = ST_DELTA_Y;
        end
      end
      ST_DELTA_Y: begin
        if (accept) begin
          state_d = ST_COUNT;
        end
      end
      ST_ABS: begin
        if (accept && status_i.bytes_done) begin
          state_d = status_i.pad_pending ? ST_PAD : ST_COUNT;
        end
      end
      ST_PAD: begin
        if (accept) begin
          state_d = ST_COUNT;
        end
      end
    endcase
  end

  // stall and command outputs
  always_comb begin
    in_stall_o = 1'b0;
    op_o       = OP_NONE;
    unique case (state_q)
      ST_COUNT: begin
        if (in_valid_i && !status_i.byte_zero) begin
          op_o = OP_LOAD_RUN;
        end
      end
      ST_VALUE: begin
        in_stall_o = !status_i.can_emit;
        if (in_valid_i && status_i.can_emit) begin
          op_o = OP_FILL_START;
        end
      end
      ST_FILL: begin
        in_stall_o = 1'b1;
        if (status_i.can_emit) begin
          op_o = OP_FILL_NEXT;
        end
      end
      ST_ESCAPE: begin
        in_stall_o = !status_i.can_emit;
        if (in_valid_i && status_i.can_emit) begin
          priority if (status_i.byte_zero) begin
            op_o = OP_EOL;
          end else if (status_i.byte_one) begin
            op_o = OP_EOB;
          end else if (status_i.byte_two) begin
            op_o = OP_NONE;
          end else begin
            op_o = OP_ABS_START;
          end
        end
      end
      ST_DELTA_X, ST_DELTA_Y: begin
        op_o = OP_NONE;
      end
      ST_ABS: begin
        in_stall_o = !status_i.can_emit;
        if (in_valid_i && status_i.can_emit) begin
          op_o = OP_ABS_BYTE;
        end
      end
      ST_PAD: begin
        if (in_valid_i) begin
          op_o = OP_PAD;
        end
      end
    endcase
  end

endmodule

>>> design/bmprle_dpath.sv
`timescale 1ns / 1ps

module bmprle_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_rle_mode_i,
  input  logic [bmprle_pkg::PIX_W-1:0]      stream_byte_i,
  input  bmprle_pkg::op_e                   op_i,
  output bmprle_pkg::dp_status_t            status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_a_o,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_b_o,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_c_o,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_d_o,
  output logic [bmprle_pkg::CNT_W-1:0]      pixel_count_o,
  output logic                              line_end_o,
  output logic                              bitmap_end_o,
  output logic                              run_last_o
);
  import bmprle_pkg::*;

  localparam logic [PIX_W-1:0] PerResultW = PIX_W'(PER_RESULT);

  logic             rle_mode_q;
  logic [PIX_W-1:0] run_length_q, run_length_d;
  logic [PIX_W-1:0] pixels_left_q, pixels_left_d;
  logic [PIX_W-1:0] bytes_left_q, bytes_left_d;
  logic             pad_q, pad_d;
  logic [PIX_W-1:0] value_q;
  logic             out_valid_q;

  logic [PIX_W-1:0] fill_src;
  logic [PIX_W-1:0] fill_byte;
  logic [CNT_W-1:0] fill_n;
  logic [CNT_W-1:0] abs_cap;
  logic [CNT_W-1:0] abs_n;
  logic [PIX_W-1:0] abs_bytes;
  logic [PIX_W-1:0] lane_byte;
  logic             is_fill;

  logic             emit;
  logic [CNT_W-1:0] emit_n;
  logic             emit_le, emit_be, emit_last;
  logic [PIX_W-1:0] lane_d [PIXEL_FIELDS];
  logic [PIX_W-1:0] lane_q [PIXEL_FIELDS];
  logic [CNT_W-1:0] count_q;
  logic             le_q, be_q, last_q;

  // status toward the controller
  assign status_o.can_emit        = !out_valid_q || !out_stall_i;
  assign status_o.byte_zero       = (stream_byte_i == PIX_W'(0));
  assign status_o.byte_one        = (stream_byte_i == PIX_W'(1));
  assign status_o.byte_two        = (stream_byte_i == PIX_W'(2));
  assign status_o.fill_last_start = (run_length_q <= PerResultW);
  assign status_o.fill_last_next  = (pixels_left_q <= PerResultW);
  assign status_o.bytes_done      = (bytes_left_q <= PIX_W'(1));
  assign status_o.pad_pending     = pad_q;

  // fill run slice: up to one result worth of pixels
  assign is_fill   = (op_i == OP_FILL_START) || (op_i == OP_FILL_NEXT);
  assign fill_src  = (op_i == OP_FILL_START) ? run_length_q : pixels_left_q;
  assign fill_byte = (op_i == OP_FILL_START) ? stream_byte_i : value_q;
  assign fill_n    = (fill_src >= PerResultW) ? CNT_W'(PER_RESULT) : fill_src[CNT_W-1:0];

  // absolute byte: up to one pixel in rle8 or two in rle4, never more than still owed
  assign abs_cap = rle_mode_q ? CNT_W'(2) : CNT_W'(1);
  assign abs_n   = (pixels_left_q < {{(PIX_W-CNT_W){1'b0}}, abs_cap}) ?
                   pixels_left_q[CNT_W-1:0] : abs_cap;

  // byte count of an absolute run
  assign abs_bytes = rle_mode_q ?
                     PIX_W'(({1'b0, stream_byte_i} + (PIX_W+1)'(1)) >> 1) : stream_byte_i;

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_n    = '0;
    emit_le   = 1'b0;
    emit_be   = 1'b0;
    emit_last = 1'b0;
    unique case (op_i)
      OP_FILL_START, OP_FILL_NEXT: begin
        emit      = 1'b1;
        emit_n    = fill_n;
        emit_last = (fill_src <= PerResultW);
      end
      OP_EOL: begin
        emit      = 1'b1;
        emit_le   = 1'b1;
        emit_last = 1'b1;
      end
      OP_EOB: begin
        emit      = 1'b1;
        emit_le   = 1'b1;
        emit_be   = 1'b1;
        emit_last = 1'b1;
      end
      OP_ABS_BYTE: begin
        emit      = (abs_n != '0);
        emit_n    = abs_n;
        emit_last = 1'b1;
      end
      OP_NONE, OP_LOAD_RUN, OP_ABS_START, OP_PAD: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // lane pixels: in rle4, nibbles alternate high then low from lane zero
  assign lane_byte = is_fill ? fill_byte : stream_byte_i;

  always_comb begin
    for (int i = 0; i < PIXEL_FIELDS; i++) begin
      if (CNT_W'(i) >= emit_n) begin
        lane_d[i] = '0;
      end else if (!rle_mode_q) begin
        lane_d[i] = lane_byte;
      end else if ((i % 2) == 0) begin
        lane_d[i] = {4'h0, lane_byte[7:4]};
      end else begin
        lane_d[i] = {4'h0, lane_byte[3:0]};
      end
    end
  end

  // run counters
  always_comb begin
    run_length_d  = run_length_q;
    pixels_left_d = pixels_left_q;
    bytes_left_d  = bytes_left_q;
    pad_d         = pad_q;
    unique case (op_i)
      OP_LOAD_RUN: begin
        run_length_d = stream_byte_i;
      end
      OP_FILL_START, OP_FILL_NEXT: begin
        pixels_left_d = fill_src - {{(PIX_W-CNT_W){1'b0}}, fill_n};
      end
      OP_ABS_START: begin
        run_length_d  = stream_byte_i;
        pixels_left_d = stream_byte_i;
        bytes_left_d  = abs_bytes;
        pad_d         = abs_bytes[0];
      end
      OP_ABS_BYTE: begin
        pixels_left_d = pixels_left_q - {{(PIX_W-CNT_W){1'b0}}, abs_n};
        if (bytes_left_q != '0) begin
          bytes_left_d = bytes_left_q - PIX_W'(1);
        end
      end
      OP_PAD: begin
        pad_d = 1'b0;
      end
      OP_NONE, OP_EOL, OP_EOB: begin
        pad_d = pad_q;
      end
      default: begin
        pad_d = pad_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_mode_q    <= 1'b0;
      run_length_q  <= '0;
      pixels_left_q <= '0;
      bytes_left_q  <= '0;
      pad_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rle_mode_q <= cfg_rle_mode_i;
      end
      run_length_q  <= run_length_d;
      pixels_left_q <= pixels_left_d;
      bytes_left_q  <= bytes_left_d;
      pad_q         <= pad_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == OP_FILL_START) begin
      value_q <= stream_byte_i;
    end
    if (emit) begin
      for (int i = 0; i < PIXEL_FIELDS; i++) begin
        lane_q[i] <= lane_d[i];
      end
      count_q <= emit_n;
      le_q    <= emit_le;
      be_q    <= emit_be;
      last_q  <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_a_o     = lane_q[0];
  assign pixel_b_o     = lane_q[1];
  assign pixel_c_o     = lane_q[2];
  assign pixel_d_o     = lane_q[3];
  assign pixel_count_o = count_q;
  assign line_end_o    = le_q;
  assign bitmap_end_o  = be_q;
  assign run_last_o    = last_q;

endmodule

>>> design/bmp_rle_line_decoder.sv
`timescale 1ns / 1ps
// output: a result sits in the output register in the cycle after the byte that causes it
// throughput: one byte per cycle while the output is not stalled, except a fill run of more
//   than four pixels, which stalls the input after its value byte until its last group of up
//   to four is issued; the fill drain counter and the single output register set this rate
// reset: rst_ni asynchronous active low; parser returns to expecting a count byte, counters
//   cleared, rle_mode back to RLE8, no result pending
module bmp_rle_line_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_rle_mode_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bmprle_pkg::PIX_W-1:0]      stream_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_a_o,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_b_o,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_c_o,
  output logic [bmprle_pkg::PIX_W-1:0]      pixel_d_o,
  output logic [bmprle_pkg::CNT_W-1:0]      pixel_count_o,
  output logic                              line_end_o,
  output logic                              bitmap_end_o,
  output logic                              run_last_o
);
  import bmprle_pkg::*;

  dp_status_t status;
  op_e        op;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  bmprle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  bmprle_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_rle_mode_i (cfg_rle_mode_i),
    .stream_byte_i  (stream_byte_i),
    .op_i           (op),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_a_o      (pixel_a_o),
    .pixel_b_o      (pixel_b_o),
    .pixel_c_o      (pixel_c_o),
    .pixel_d_o      (pixel_d_o),
    .pixel_count_o  (pixel_count_o),
    .line_end_o     (line_end_o),
    .bitmap_end_o   (bitmap_end_o),
    .run_last_o     (run_last_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bmprle_pkg::*;

  // escape codes of the compressed stream
  localparam logic [7:0] ESC_MARK  = 8'h00;
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  localparam logic MODE_RLE8 = 1'b0;
  localparam logic MODE_RLE4 = 1'b1;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_BYTES = 170;

  // one decoded group of up to four pixels
  typedef struct packed {
    logic [PIX_W-1:0] pix_a;
    logic [PIX_W-1:0] pix_b;
    logic [PIX_W-1:0] pix_c;
    logic [PIX_W-1:0] pix_d;
    logic [CNT_W-1:0] count;
    logic             line_end;
    logic             bitmap_end;
    logic             last;
  } pixel_group_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_rle_mode_i = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic [PIX_W-1:0] stream_byte_i  = '0;
  logic             out_stall_i    = 1'b0;
  logic             cfg_ready_o;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [PIX_W-1:0] pixel_a_o;
  logic [PIX_W-1:0] pixel_b_o;
  logic [PIX_W-1:0] pixel_c_o;
  logic [PIX_W-1:0] pixel_d_o;
  logic [CNT_W-1:0] pixel_count_o;
  logic             line_end_o;
  logic             bitmap_end_o;
  logic             run_last_o;

  bmp_rle_line_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_rle_mode_i (cfg_rle_mode_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_a_o      (pixel_a_o),
    .pixel_b_o      (pixel_b_o),
    .pixel_c_o      (pixel_c_o),
    .pixel_d_o      (pixel_d_o),
    .pixel_count_o  (pixel_count_o),
    .line_end_o     (line_end_o),
    .bitmap_end_o   (bitmap_end_o),
    .run_last_o     (run_last_o)
  );

  logic [PIX_W-1:0] stream_q[$];
  pixel_group_t     expected_groups[$];

  // decoder shadow state
  logic   dec_mode = MODE_RLE8;
  state_e dec_phase = ST_COUNT;
  int     dec_run;
  int     dec_left;
  int     dec_bytes;
  logic   dec_pad;
  logic   dec_high = 1'b1;

  logic quiet = 1'b0;
  int   hold_asked = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   send_gap = 0;
  int   mismatches = 0;
  int   bytes_taken = 0;
  int   bytes_pushed = 0;
  int   groups_seen = 0;
  int   mode_writes = 0;
  int   bytes_queued = 0;
  int   stuck_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // next pixel of a byte, alternating nibbles in rle4
  function automatic logic [PIX_W-1:0] take_pixel(input logic [7:0] b);
    logic [PIX_W-1:0] p;
    if (dec_mode == MODE_RLE8) begin
      return b;
    end
    p = dec_high ? {4'h0, b[7:4]} : {4'h0, b[3:0]};
    dec_high = !dec_high;
    return p;
  endfunction

  function automatic void queue_group(input logic [PIX_W-1:0] px[4], input int n,
                                      input logic le, input logic be, input logic last);
    pixel_group_t g;
    g.pix_a      = px[0];
    g.pix_b      = px[1];
    g.pix_c      = px[2];
    g.pix_d      = px[3];
    g.count      = CNT_W'(n);
    g.line_end   = le;
    g.bitmap_end = be;
    g.last       = last;
    expected_groups.push_back(g);
  endfunction

  // advance the shadow parser by one accepted byte
  function automatic void decode_byte(input logic [7:0] b);
    logic [PIX_W-1:0] px[4];
    int n;
    for (int i = 0; i < 4; i++) px[i] = '0;
    case (dec_phase)
      ST_VALUE: begin
        dec_left = dec_run;
        dec_high = 1'b1;
        while (dec_left > 0) begin
          n = (dec_left < PER_RESULT) ? dec_left : PER_RESULT;
          for (int i = 0; i < 4; i++) px[i] = (i < n) ? take_pixel(b) : '0;
          dec_left -= n;
          queue_group(px, n, 1'b0, 1'b0, dec_left == 0);
        end
        dec_phase = ST_COUNT;
      end
      ST_ESCAPE: begin
        if (b == ESC_EOL) begin
          queue_group(px, 0, 1'b1, 1'b0, 1'b1);
          dec_phase = ST_COUNT;
        end else if (b == ESC_EOB) begin
          queue_group(px, 0, 1'b1, 1'b1, 1'b1);
          dec_phase = ST_COUNT;
        end else if (b == ESC_DELTA) begin
          dec_phase = ST_DELTA_X;
        end else begin
          dec_run   = b;
          dec_left  = b;
          dec_bytes = (dec_mode == MODE_RLE4) ? ((int'(b) + 1) >> 1) : int'(b);
          dec_pad   = dec_bytes[0];
          dec_phase = ST_ABS;
        end
      end
      ST_DELTA_X: dec_phase = ST_DELTA_Y;
      ST_DELTA_Y: dec_phase = ST_COUNT;
      ST_ABS: begin
        dec_high = 1'b1;
        n = (dec_mode == MODE_RLE4) ? 2 : 1;
        if (n > dec_left) n = dec_left;
        if (n > 0) begin
          for (int i = 0; i < 4; i++) px[i] = (i < n) ? take_pixel(b) : '0;
          dec_left -= n;
          queue_group(px, n, 1'b0, 1'b0, 1'b1);
        end
        if (dec_bytes > 0) dec_bytes--;
        if (dec_bytes == 0) dec_phase = dec_pad ? ST_PAD : ST_COUNT;
      end
      ST_PAD: begin
        dec_pad   = 1'b0;
        dec_phase = ST_COUNT;
      end
      default: begin
        if (b == ESC_MARK) begin
          dec_phase = ST_ESCAPE;
        end else begin
          dec_run   = b;
          dec_phase = ST_VALUE;
        end
      end
    endcase
  endfunction

  function automatic void cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // byte sender, fed from the stream queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      stream_byte_i <= '0;
      send_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else if (stream_q.size() > 0) begin
        in_valid_i    <= 1'b1;
        stream_byte_i <= stream_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // pixel receiver with random stalls and the requested long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // predict on accepted bytes, check accepted pixel groups
  always @(posedge clk_i) begin
    pixel_group_t exp_g;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(stream_byte_i);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        groups_seen++;
        if (expected_groups.size() == 0) begin
          $display("%0t: unexpected pixel group, expected none, actual count %0d",
                   $time, pixel_count_o);
          mismatches++;
        end else begin
          exp_g = expected_groups.pop_front();
          cmp_field("pixel_a", exp_g.pix_a, pixel_a_o);
          cmp_field("pixel_b", exp_g.pix_b, pixel_b_o);
          cmp_field("pixel_c", exp_g.pix_c, pixel_c_o);
          cmp_field("pixel_d", exp_g.pix_d, pixel_d_o);
          cmp_field("pixel_count", exp_g.count, pixel_count_o);
          cmp_field("line_end", exp_g.line_end, line_end_o);
          cmp_field("bitmap_end", exp_g.bitmap_end, bitmap_end_o);
          cmp_field("run_last", exp_g.last, run_last_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back(b);
    bytes_queued++;
    bytes_pushed++;
  endtask

  task automatic push_fill(input logic [7:0] cnt, input logic [7:0] value);
    push_byte(cnt);
    push_byte(value);
  endtask

  task automatic push_escape(input logic [7:0] code);
    push_byte(ESC_MARK);
    push_byte(code);
  endtask

  // absolute run of n pixels with padding, sized for the current mode
  task automatic push_absolute(input int n);
    int nbytes;
    nbytes = (dec_mode == MODE_RLE4) ? (n + 1) / 2 : n;
    push_escape(8'(n));
    for (int i = 0; i < nbytes; i++) push_byte(8'($urandom_range(0, 255)));
    if (nbytes % 2 == 1) push_byte(8'($urandom_range(0, 255)));
  endtask

  // sender pause until every pushed byte is accepted and every group is out
  task automatic drain_all();
    while (bytes_taken != bytes_pushed || expected_groups.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_rle_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dec_mode = m;
    mode_writes++;
  endtask

  initial begin
    int r;
    int phase_end;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rle8: run extremes under a long receiver hold, markers, delta, absolute run
    write_mode(MODE_RLE8);
    push_fill(8'h01, 8'h00);
    hold_asked++;
    push_fill(8'hff, 8'hff);
    push_escape(ESC_EOL);
    push_escape(ESC_EOB);
    push_escape(ESC_DELTA);
    push_byte(8'hff);
    push_byte(8'h00);
    push_absolute(3);
    drain_all();

    // directed rle4: odd fill and odd absolute run with pad
    write_mode(MODE_RLE4);
    push_fill(8'h07, 8'h5a);
    push_absolute(5);
    // absolute run cut by a switch to rle8
    push_escape(8'h07);
    push_byte(8'hc3);
    push_byte(8'h3c);
    drain_all();
    write_mode(MODE_RLE8);
    push_byte(8'h81);
    push_byte(8'h7e);
    // rle8 absolute run finished in rle4, last byte owes no pixel
    push_escape(8'h03);
    push_byte(8'h96);
    drain_all();
    write_mode(MODE_RLE4);
    push_byte(8'hf0);
    push_byte(8'h0f);
    push_byte(8'h55);
    drain_all();

    // random: mostly well-formed commands, some raw noise, random mode writes between phases
    bytes_queued = 0;
    while (bytes_queued < RANDOM_BYTES) begin
      if (bytes_queued >= RANDOM_BYTES - 40) quiet = 1'b1;
      phase_end = bytes_queued + $urandom_range(20, 45);
      while (bytes_queued < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          push_fill(8'($urandom_range(13, 255)), 8'($urandom_range(0, 255)));
        end else if (r < 40) begin
          push_fill(8'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
        end else if (r < 50) begin
          push_escape(ESC_EOL);
        end else if (r < 55) begin
          push_escape(ESC_EOB);
        end else if (r < 62) begin
          push_escape(ESC_DELTA);
          push_byte(8'($urandom_range(0, 255)));
          push_byte(8'($urandom_range(0, 255)));
        end else if (r < 88) begin
          push_absolute($urandom_range(3, 20));
        end else begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
      end
      drain_all();
      write_mode(1'($urandom_range(0, 1)));
    end
    drain_all();

    $display("run covered %0d stream bytes and %0d pixel groups over %0d mode writes",
             bytes_taken, groups_seen, mode_writes);
    $display("both rle8 and rle4, fills up to 255 pixels, escapes, deltas and absolute runs");
    if (mismatches == 0 && expected_groups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
